>>> src/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// Shared field widths, operation codes and command types of the compacting
// array store.
// ----------------------------------------------------------------------------
package cas_pkg;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int IDX_F_W  = 6;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   localparam logic [MODE_W-1:0] MODE_APPEND   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd3;

   // work the back end has to carry out for one request
   localparam logic [KIND_W-1:0] KIND_REPORT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value;
      logic [IDX_F_W-1:0]        index;
      logic [FILL_W-1:0]         fill;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] element;
      logic [IDX_F_W-1:0]        element_index;
      logic [FILL_W-1:0]         fill_count;
      logic                      last;
   } rsp_type;

endpackage

>>> src/cas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_front
// Accepts requests, checks them against a running fill count and queues a
// fully classified command for the back end.
// ----------------------------------------------------------------------------
module cas_front import cas_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MODE_W-1:0]         mode,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [IDX_F_W-1:0]        position,
   input  logic                      q_full,
   output logic                      push,
   output cmd_type                   push_cmd
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             accept;
   logic             is_full;
   logic             is_empty;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_full   = (cnt_ff == CNT_W'(DEPTH));
   assign is_empty  = (cnt_ff == '0);

   always_comb begin
      push            = 1'b0;
      cnt_in          = cnt_ff;
      push_cmd.kind   = KIND_REPORT;
      push_cmd.status = STATUS_OK;
      push_cmd.value  = value;
      push_cmd.index  = '0;
      push_cmd.fill   = FILL_W'(cnt_ff);
      case (mode)
         MODE_APPEND: begin
            push = accept;
            if (is_full) begin
               push_cmd.status = STATUS_FULL;
            end else begin
               push_cmd.kind  = KIND_APPEND;
               push_cmd.index = IDX_F_W'(cnt_ff);
               push_cmd.fill  = FILL_W'(cnt_ff + CNT_W'(1));
               if (accept) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         MODE_DELETE: begin
            push = accept;
            if (is_empty) begin
               push_cmd.status = STATUS_EMPTY;
            end else if (FILL_W'(position) >= FILL_W'(cnt_ff)) begin
               push_cmd.status = STATUS_BAD_POS;
            end else begin
               push_cmd.kind  = KIND_DELETE;
               push_cmd.index = position;
               push_cmd.fill  = FILL_W'(cnt_ff - CNT_W'(1));
               if (accept) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         MODE_TRAVERSE: begin
            push = accept;
            if (is_empty) begin
               push_cmd.status = STATUS_EMPTY;
            end else begin
               push_cmd.kind = KIND_TRAVERSE;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cnt_ff))
      else $error("fill count moved without a request");

endmodule

>>> src/cas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cas_queue import cas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/cas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_back
// Executes queued commands against the entry memory: append writes, delete
// reads the removed entry and shifts later entries down, traverse streams
// all entries. Results leave through an output register.
// ----------------------------------------------------------------------------
module cas_back import cas_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type head,
   output logic    pop,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EMIT  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_TRAV  = 2'd3;

   logic signed [VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic [1:0]                state_ff;
   logic [1:0]                state_in;
   cmd_type                   cmd_ff;
   cmd_type                   cmd_in;
   logic signed [VALUE_W-1:0] elem_ff;
   logic signed [VALUE_W-1:0] elem_in;
   logic [CNT_W-1:0]          idx_ff;
   logic [CNT_W-1:0]          idx_in;
   logic [CNT_W-1:0]          idx_nxt;
   logic                      pend_ff;
   logic                      pend_in;
   logic                      first_ff;
   logic                      first_in;
   logic [IDX_W-1:0]          pend_addr_ff;
   logic [IDX_W-1:0]          pend_addr_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   logic                      out_free;
   logic                      load;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_nxt    = idx_ff + CNT_W'(1);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      elem_in      = elem_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      pend_addr_in = pend_addr_ff;
      pop          = 1'b0;
      load         = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               cmd_in  = head;
               elem_in = '0;
               case (head.kind)
                  KIND_APPEND: begin
                     wr_en    = 1'b1;
                     wr_addr  = head.index[IDX_W-1:0];
                     wr_data  = head.value;
                     state_in = ST_EMIT;
                  end
                  KIND_DELETE: begin
                     rd_en        = 1'b1;
                     rd_addr      = head.index[IDX_W-1:0];
                     pend_in      = 1'b1;
                     first_in     = 1'b1;
                     pend_addr_in = head.index[IDX_W-1:0];
                     idx_in       = CNT_W'(head.index) + CNT_W'(1);
                     state_in     = ST_SHIFT;
                  end
                  KIND_TRAVERSE: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_TRAV;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load                 = 1'b1;
               rsp_in.status        = cmd_ff.status;
               rsp_in.element       = elem_ff;
               rsp_in.element_index = cmd_ff.index;
               rsp_in.fill_count    = cmd_ff.fill;
               rsp_in.last          = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            // read runs one entry ahead of the write it feeds
            first_in = 1'b0;
            if (pend_ff) begin
               if (first_ff) begin
                  elem_in = rd_data_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pend_addr_ff - IDX_W'(1);
               end
            end
            if (FILL_W'(idx_ff) <= cmd_ff.fill) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff[IDX_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[IDX_W-1:0];
               idx_in       = idx_nxt;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_TRAV: begin
            if (out_free) begin
               load                 = 1'b1;
               rsp_in.status        = STATUS_OK;
               rsp_in.element       = rd_data_ff;
               rsp_in.element_index = IDX_F_W'(idx_ff);
               rsp_in.fill_count    = cmd_ff.fill;
               rsp_in.last          = (FILL_W'(idx_nxt) == cmd_ff.fill);
               if (FILL_W'(idx_nxt) == cmd_ff.fill) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_nxt[IDX_W-1:0];
                  idx_in  = idx_nxt;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      elem_ff      <= elem_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result register overwritten before it was taken");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en && state_ff == ST_SHIFT) |-> (wr_addr < rd_addr))
      else $error("shift write does not trail its read");

   a_trav_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TRAV |-> FILL_W'(idx_ff) < cmd_ff.fill)
      else $error("traversal index beyond fill count");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff != ST_IDLE)
      else $error("popped command did not start");

endmodule

>>> src/compacting_array_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_array_store_unit
// Ordered store of up to DEPTH signed 32-bit values: append, delete at a
// position with compaction, and in-order traversal.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_     | in        | tuser: mode; tdata: value, position
//  rsp_     | out       | tdata: status, element, element_index, fill_count;
//           |           | tlast: last result of a request
//
//  A request enters the command queue in the cycle it is accepted; its first
//  result is registered after the queue entry and the back end's command register.
//  Append and any error answer: the back end goes from idle to its emit state.
//  Delete at p: later entries shift down, one memory read and write a cycle.
//  Traverse: one entry read a cycle from the memory while the result register is free.
//  Reset clears control and the fill count only; entry memory needs no clear.
//  A stalled result holds the back end; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module compacting_array_store_unit import cas_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], element[33:2],
                                    // element_index[39:34], fill_count[46:40]
   output logic        rsp_tlast
);

   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head;
   rsp_type rsp;

   cas_front #(
      .DEPTH(DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .mode     (req_tuser),
      .value    (req_tdata[VALUE_W-1:0]),
      .position (req_tdata[VALUE_W+IDX_F_W-1:VALUE_W]),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   cas_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (pop),
      .head    (head),
      .empty   (q_empty)
   );

   cas_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.fill_count, rsp.element_index, rsp.element, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule
